@@ hdl/ultrasonic_echo_ranger_top_defines.svh @@
// Assertion macros used by the ranger sequencer RTL.
`ifndef ULTRASONIC_ECHO_RANGER_TOP_DEFINES_SVH
`define ULTRASONIC_ECHO_RANGER_TOP_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define UER_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("ranger assertion failed");

// Consequence that must hold at the clock edge after the antecedent.
`define UER_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ranger assertion failed");

`endif

@@ hdl/uer_pkg.sv @@
// Types and constants of the ultrasonic echo ranger.
`default_nettype none
package uer_pkg;

  localparam int TICK_BITS   = 16;
  localparam int PC_W        = 8;
  localparam int PULSE_W     = 8;
  localparam int TIMEOUT_W   = 16;
  localparam int DIST_W      = 15;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam int SPEED_MUL   = 1124;
  localparam int SPEED_MUL_W = 11;
  localparam int SPEED_SHIFT = 12;
  localparam int PROD_W      = TICK_BITS + SPEED_MUL_W;
  localparam int SHIFTED_W   = PROD_W - SPEED_SHIFT;
  localparam int CMP_W       = (SHIFTED_W > DIST_W) ? SHIFTED_W : DIST_W;
  localparam int EL_CMP_W    = (TICK_BITS > TIMEOUT_W) ? TICK_BITS : TIMEOUT_W;

  localparam int IN_DATA_W   = 8;
  localparam int OUT_DATA_W  = 24;

  typedef logic [TICK_BITS-1:0] tick_t;
  typedef logic [PC_W-1:0]      pcount_t;
  typedef logic [DIST_W-1:0]    dist_t;
  typedef logic [CMP_W-1:0]     dcmp_t;
  typedef logic [EL_CMP_W-1:0]  elcmp_t;

  localparam tick_t   TICK_MAX  = '1;
  localparam pcount_t LOW_TICKS = PC_W'(2);

  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_PULSE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT       = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RANGE     = CFG_IDX_W'(2);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TLOW,
    PH_THIGH,
    PH_WAIT_END,
    PH_WAIT_RISE,
    PH_MEASURE
  } phase_t;

  typedef struct packed {
    logic [PULSE_W-1:0]   trigger_pulse_ticks;
    logic [TIMEOUT_W-1:0] timeout_ticks;
    dist_t                max_range;
  } uer_cfg_t;

  typedef struct packed {
    logic  busy_res;
    logic  no_echo;
    dist_t distance;
    logic  done_res;
    logic  trigger_out;
  } uer_result_t;

endpackage
`default_nettype wire

@@ hdl/uer_range.sv @@
// Converts an echo width to a distance in 1/16 cm and clamps it to the maximum range.
`default_nettype none
module uer_range (
  input  uer_pkg::tick_t echo_width,
  input  uer_pkg::dist_t max_range,
  output uer_pkg::dist_t range_dist
);
  import uer_pkg::*;

  logic [PROD_W-1:0]    product;
  logic [SHIFTED_W-1:0] shifted;
  dcmp_t                shifted_ext;
  dcmp_t                max_ext;

  assign product     = PROD_W'(echo_width) * PROD_W'(SPEED_MUL);
  assign shifted     = product[PROD_W-1:SPEED_SHIFT];
  assign shifted_ext = dcmp_t'(shifted);
  assign max_ext     = dcmp_t'(max_range);
  assign range_dist  = (shifted_ext > max_ext) ? max_range : DIST_W'(shifted_ext);

endmodule
`default_nettype wire

@@ hdl/uer_fsm.sv @@
// Measurement sequencer: trigger pulse, echo wait, width count and timeout.
`default_nettype none
`include "ultrasonic_echo_ranger_top_defines.svh"
module uer_fsm (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic                start_req,
  input  logic                echo_level,
  input  uer_pkg::uer_cfg_t   cfg,
  output uer_pkg::uer_result_t res
);
  import uer_pkg::*;

  phase_t  phase, phase_next;
  pcount_t phase_counter, phase_counter_next;
  tick_t   elapsed_ticks, elapsed_ticks_next;
  tick_t   echo_width, echo_width_next;

  phase_t            ph_start;
  pcount_t           pc_start;
  pcount_t           pc_inc;
  pcount_t           pulse;
  tick_t             el_inc;
  logic              fell;
  dist_t             range_dist;

  uer_range u_range (
    .echo_width (echo_width),
    .max_range  (cfg.max_range),
    .range_dist (range_dist)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      phase_counter <= '0;
      elapsed_ticks <= '0;
      echo_width    <= '0;
    end else if (step) begin
      phase         <= phase_next;
      phase_counter <= phase_counter_next;
      elapsed_ticks <= elapsed_ticks_next;
      echo_width    <= echo_width_next;
    end
  end

  always_comb begin
    ph_start = (phase == PH_IDLE && start_req) ? PH_TLOW : phase;
    pc_start = (phase == PH_IDLE && start_req) ? '0 : phase_counter;
    pc_inc   = pc_start + PC_W'(1);
    pulse    = (cfg.trigger_pulse_ticks == '0) ? PC_W'(1) : cfg.trigger_pulse_ticks;
    el_inc   = (elapsed_ticks == TICK_MAX) ? elapsed_ticks : elapsed_ticks + TICK_BITS'(1);
    fell     = 1'b0;

    phase_next         = ph_start;
    phase_counter_next = pc_start;
    elapsed_ticks_next = elapsed_ticks;
    echo_width_next    = echo_width;
    res                = '0;

    case (ph_start)
      PH_IDLE: begin
        phase_next = PH_IDLE;
      end
      PH_TLOW: begin
        if (pc_inc >= LOW_TICKS) begin
          phase_next         = PH_THIGH;
          phase_counter_next = '0;
        end else begin
          phase_counter_next = pc_inc;
        end
      end
      PH_THIGH: begin
        res.trigger_out = 1'b1;
        if (pc_inc >= pulse) begin
          phase_next         = PH_WAIT_END;
          phase_counter_next = '0;
          elapsed_ticks_next = '0;
          echo_width_next    = '0;
        end else begin
          phase_counter_next = pc_inc;
        end
      end
      PH_WAIT_END, PH_WAIT_RISE, PH_MEASURE: begin
        if (ph_start == PH_WAIT_END) begin
          if (!echo_level) phase_next = PH_WAIT_RISE;
        end else if (ph_start == PH_WAIT_RISE) begin
          if (echo_level) begin
            phase_next      = PH_MEASURE;
            echo_width_next = TICK_BITS'(1);
          end
        end else if (echo_level) begin
          if (echo_width != TICK_MAX) echo_width_next = echo_width + TICK_BITS'(1);
        end else begin
          // Echo fell: the width held so far gives the range.
          fell           = 1'b1;
          res.done_res   = 1'b1;
          res.distance   = range_dist;
          phase_next     = PH_IDLE;
        end
        if (!fell) begin
          elapsed_ticks_next = el_inc;
          if (elcmp_t'(el_inc) >= elcmp_t'(cfg.timeout_ticks)) begin
            res.done_res = 1'b1;
            res.no_echo  = 1'b1;
            res.distance = cfg.max_range;
            phase_next   = PH_IDLE;
          end
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase

    res.busy_res = (phase_next != PH_IDLE);
  end

  `UER_ASSERT_ALWAYS(a_done_not_busy, !(res.done_res && res.busy_res))
  `UER_ASSERT_ALWAYS(a_no_echo_with_done, !res.no_echo || res.done_res)
  `UER_ASSERT_ALWAYS(a_dist_clamped, !res.done_res || (res.distance <= cfg.max_range))
  `UER_ASSERT_NEXT(a_idle_holds, step && phase == PH_IDLE && !start_req, phase == PH_IDLE)

endmodule
`default_nettype wire

@@ hdl/ultrasonic_echo_ranger_top.sv @@
// Ultrasonic echo ranger: tick stream in, per-tick status stream out.
// A beat taken on s_axis is held in the input register, then in the output register on m_axis.
// Throughput: one beat per cycle while m_axis_tready is high; the per-tick sequencer
// step and the range multiply sit between the input register and the output register.
// Reset (rst, synchronous) returns the sequencer to idle, empties both
// registers and loads the configuration defaults.
`default_nettype none
module ultrasonic_echo_ranger_top (
  input  logic                                   clk,
  input  logic                                   rst,
  // s_axis_tdata: [0] start_req, [1] echo_level, rest zero
  input  logic [uer_pkg::IN_DATA_W-1:0]          s_axis_tdata,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // m_axis_tdata: [0] trigger_out, [1] done_res, [16:2] distance,
  // [17] no_echo, [18] busy_res, rest zero
  output logic [uer_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  input  logic                                   cfg_we,
  input  logic [uer_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [uer_pkg::CFG_DATA_W-1:0]         cfg_data
);
  import uer_pkg::*;

  uer_cfg_t    cfg;
  logic        in_valid;
  logic        in_start;
  logic        in_echo;
  logic        out_valid;
  uer_result_t out_res;
  uer_result_t res;
  logic        step;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trigger_pulse_ticks <= PULSE_W'(10);
      cfg.timeout_ticks       <= TIMEOUT_W'(23500);
      cfg.max_range           <= DIST_W'(6400);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TRIGGER_PULSE: cfg.trigger_pulse_ticks <= cfg_data[PULSE_W-1:0];
        CFG_TIMEOUT:       cfg.timeout_ticks       <= cfg_data[TIMEOUT_W-1:0];
        CFG_MAX_RANGE:     cfg.max_range           <= cfg_data[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // The input beat is processed once the output register is free or draining.
  assign step          = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_start <= s_axis_tdata[0];
      in_echo  <= s_axis_tdata[1];
    end
  end

  uer_fsm u_fsm (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .start_req  (in_start),
    .echo_level (in_echo),
    .cfg        (cfg),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_DATA_W'(out_res);

endmodule
`default_nettype wire
